// File: hw/rtl/efrg_pkg.sv
// shared types and constants for the resource grant arbiter
// no dependencies
package efrg_pkg;

    localparam int MAX_WAITERS_DEF = 16;
    localparam int TIME_BITS_DEF   = 32;
    localparam int ID_BITS         = 8;
    localparam int CFG_IDX_BITS    = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCHED_MODE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BURNOUT    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COOLDOWN   = 2'd2;

    // item codes
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // scheduling codes
    localparam logic SCHED_EDF  = 1'b0;
    localparam logic SCHED_FIFO = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DROP
    } t_state;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

// File: hw/rtl/efrg_cell.sv
// one entry of the waiting list: requester id and last-service time
// depends on efrg_pkg
module efrg_cell #(
    parameter int TIME_BITS = efrg_pkg::TIME_BITS_DEF
) (
    input  logic                         i_clk,
    input  efrg_pkg::t_cell_ctl          i_ctl,
    input  logic [efrg_pkg::ID_BITS-1:0] i_new_id,
    input  logic [TIME_BITS-1:0]         i_new_time,
    input  logic [efrg_pkg::ID_BITS-1:0] i_nbr_id,
    input  logic [TIME_BITS-1:0]         i_nbr_time,
    output logic [efrg_pkg::ID_BITS-1:0] o_id,
    output logic [TIME_BITS-1:0]         o_time
);

    logic [efrg_pkg::ID_BITS-1:0] r_id;
    logic [TIME_BITS-1:0]         r_time;

    // load from the input word, or take the neighbor's entry
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_id   <= i_new_id;
            r_time <= i_new_time;
        end else if (i_ctl.shift) begin
            r_id   <= i_nbr_id;
            r_time <= i_nbr_time;
        end
    end

    assign o_id   = r_id;
    assign o_time = r_time;

endmodule

// File: hw/rtl/efrg_pick.sv
// running earliest-deadline tracker fed from the head of the cell row
// depends on efrg_pkg
module efrg_pick #(
    parameter int TIME_BITS   = efrg_pkg::TIME_BITS_DEF,
    parameter int MAX_WAITERS = efrg_pkg::MAX_WAITERS_DEF,
    localparam int IDXW       = $clog2(MAX_WAITERS)
) (
    input  logic                         i_clk,
    input  logic                         i_step,
    input  logic                         i_first,
    input  logic [IDXW-1:0]              i_idx,
    input  logic [efrg_pkg::ID_BITS-1:0] i_id,
    input  logic [TIME_BITS-1:0]         i_time,
    input  logic [TIME_BITS-1:0]         i_burnout,
    output logic [IDXW-1:0]              o_best_idx,
    output logic [efrg_pkg::ID_BITS-1:0] o_best_id
);

    logic [TIME_BITS:0]           w_dl;
    logic [TIME_BITS:0]           r_best_dl;
    logic [IDXW-1:0]              r_best_idx;
    logic [efrg_pkg::ID_BITS-1:0] r_best_id;

    // deadline kept one bit wider so it never wraps
    assign w_dl = {1'b0, i_time} + {1'b0, i_burnout};

    // strict less-than keeps the earliest entry on ties
    always_ff @(posedge i_clk) begin
        if (i_step && (i_first || (w_dl < r_best_dl))) begin
            r_best_dl  <= w_dl;
            r_best_idx <= i_idx;
            r_best_id  <= i_id;
        end
    end

    assign o_best_idx = r_best_idx;
    assign o_best_id  = r_best_id;

endmodule

// File: hw/rtl/edf_fifo_resource_grant.sv
// resource grant arbiter: top level with sequencer, config and cell row
// depends on efrg_pkg, efrg_cell, efrg_pick
//
// enqueue and release on an empty list give their word in the cycle after
// start; a fifo grant passes through the drop state, an edf grant through the
// scan state (one full rotation of the cell row past the deadline tracker)
// and then the drop state (for the row to close the gap). busy drops in the cycle the
// result word is shown, so the next item can start then. the result strobe
// o_done is high for one cycle and cannot be stalled. synchronous reset
// clears the sequencer, the waiter count and the config registers; list
// entries stay undefined until written.
module edf_fifo_resource_grant #(
    parameter int MAX_WAITERS = efrg_pkg::MAX_WAITERS_DEF,
    parameter int TIME_BITS   = efrg_pkg::TIME_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // command side
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_mode,
    input  logic [efrg_pkg::ID_BITS-1:0]      i_requester_id,
    input  logic [TIME_BITS-1:0]              i_last_service_time,
    input  logic [TIME_BITS-1:0]              i_now_time,
    // result side
    output logic                              o_done,
    output logic                              o_grant_valid,
    output logic [efrg_pkg::ID_BITS-1:0]      o_granted_id,
    output logic                              o_resource_free,
    output logic [TIME_BITS-1:0]              o_ready_time,
    output logic                              o_overflow,
    // config write port
    input  logic                              i_cfg_we,
    input  logic [efrg_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [TIME_BITS-1:0]              i_cfg_data
);

    localparam int IDXW = $clog2(MAX_WAITERS);
    localparam int CNTW = $clog2(MAX_WAITERS + 1);
    localparam logic [CNTW-1:0] CNT_FULL = CNTW'(MAX_WAITERS);
    localparam logic [IDXW-1:0] IDX_LAST = IDXW'(MAX_WAITERS - 1);

    efrg_pkg::t_state r_state, n_state;

    // config registers
    logic                 r_sched;
    logic [TIME_BITS-1:0] r_burnout;
    logic [TIME_BITS-1:0] r_cooldown;

    // list and sequencer state
    logic [CNTW-1:0]              r_count;
    logic [IDXW-1:0]              r_scan_idx;
    logic                         r_use_pick;
    logic [efrg_pkg::ID_BITS-1:0] r_gid;
    logic [TIME_BITS-1:0]         r_now;

    // result word registers
    logic                         r_done;
    logic                         r_grant;
    logic [efrg_pkg::ID_BITS-1:0] r_gid_out;
    logic                         r_free;
    logic [TIME_BITS-1:0]         r_ready;
    logic                         r_ovf;

    // cell row
    efrg_pkg::t_cell_ctl          w_ctl  [MAX_WAITERS];
    logic [efrg_pkg::ID_BITS-1:0] w_id   [MAX_WAITERS];
    logic [TIME_BITS-1:0]         w_time [MAX_WAITERS];

    logic                         w_accept;
    logic                         w_full;
    logic                         w_scan_step;
    logic                         w_enq_write;
    logic [IDXW-1:0]              w_drop_pos;
    logic [efrg_pkg::ID_BITS-1:0] w_drop_id;
    logic [IDXW-1:0]              w_best_idx;
    logic [efrg_pkg::ID_BITS-1:0] w_best_id;

    // busy is low only in idle, so a word is taken there
    assign w_accept = start && (r_state == efrg_pkg::ST_IDLE);
    assign w_full   = (r_count == CNT_FULL);

    // winner position and id: tracker result in edf, head of list in fifo
    assign w_drop_pos = r_use_pick ? w_best_idx : '0;
    assign w_drop_id  = r_use_pick ? w_best_id  : r_gid;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            efrg_pkg::ST_IDLE: begin
                if (w_accept && (i_mode == efrg_pkg::OP_RELEASE) && (r_count != '0)) begin
                    if (r_sched == efrg_pkg::SCHED_FIFO) begin
                        n_state = efrg_pkg::ST_DROP;
                    end else begin
                        n_state = efrg_pkg::ST_SCAN;
                    end
                end
            end
            efrg_pkg::ST_SCAN: begin
                // full rotation brings the row back to list order
                if (r_scan_idx == IDX_LAST) begin
                    n_state = efrg_pkg::ST_DROP;
                end
            end
            efrg_pkg::ST_DROP: begin
                n_state = efrg_pkg::ST_IDLE;
            end
            default: begin
                n_state = efrg_pkg::ST_IDLE;
            end
        endcase
    end

    // state-decoded controls
    always_comb begin
        busy        = 1'b1;
        w_scan_step = 1'b0;
        w_enq_write = 1'b0;
        for (int i = 0; i < MAX_WAITERS; i++) begin
            w_ctl[i] = '0;
        end
        case (r_state)
            efrg_pkg::ST_IDLE: begin
                busy        = 1'b0;
                w_enq_write = w_accept && (i_mode == efrg_pkg::OP_ENQUEUE) && !w_full;
                for (int i = 0; i < MAX_WAITERS; i++) begin
                    w_ctl[i].load = w_enq_write && (r_count == CNTW'(i));
                end
            end
            efrg_pkg::ST_SCAN: begin
                // only live entries feed the tracker
                w_scan_step = (CNTW'(r_scan_idx) < r_count);
                for (int i = 0; i < MAX_WAITERS; i++) begin
                    w_ctl[i].shift = 1'b1;
                end
            end
            efrg_pkg::ST_DROP: begin
                // entries behind the winner move up one place
                for (int i = 0; i < MAX_WAITERS; i++) begin
                    w_ctl[i].shift = (IDXW'(i) >= w_drop_pos);
                end
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= efrg_pkg::ST_IDLE;
            r_count    <= '0;
            r_done     <= 1'b0;
            r_sched    <= 1'b0;
            r_burnout  <= '0;
            r_cooldown <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    efrg_pkg::CFG_SCHED_MODE: r_sched    <= i_cfg_data[0];
                    efrg_pkg::CFG_BURNOUT:    r_burnout  <= i_cfg_data;
                    efrg_pkg::CFG_COOLDOWN:   r_cooldown <= i_cfg_data;
                    default: begin
                        r_sched <= r_sched;
                    end
                endcase
            end
            if (w_enq_write) begin
                r_count <= r_count + CNTW'(1);
            end
            // enqueue or release on empty list answers at once, a grant after the drop
            r_done <= ((r_state == efrg_pkg::ST_IDLE) && w_accept &&
                       ((i_mode == efrg_pkg::OP_ENQUEUE) || (r_count == '0))) ||
                      (r_state == efrg_pkg::ST_DROP);
            if (r_state == efrg_pkg::ST_DROP) begin
                r_count <= r_count - CNTW'(1);
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == efrg_pkg::ST_SCAN) begin
            r_scan_idx <= r_scan_idx + IDXW'(1);
        end
        if (r_state == efrg_pkg::ST_IDLE && w_accept) begin
            r_scan_idx <= '0;
            r_now      <= i_now_time;
            r_use_pick <= (r_sched == efrg_pkg::SCHED_EDF);
            r_gid      <= w_id[0];
            r_grant    <= 1'b0;
            r_gid_out  <= '0;
            if (i_mode == efrg_pkg::OP_ENQUEUE) begin
                r_free  <= 1'b0;
                r_ready <= '0;
                r_ovf   <= w_full;
            end else begin
                r_free  <= (r_count == '0);
                r_ready <= i_now_time + r_cooldown;
                r_ovf   <= 1'b0;
            end
        end
        if (r_state == efrg_pkg::ST_DROP) begin
            r_grant   <= 1'b1;
            r_gid_out <= w_drop_id;
            r_free    <= 1'b0;
            r_ready   <= r_now + r_cooldown;
            r_ovf     <= 1'b0;
        end
    end

    // row of cells, each taking its successor's entry on a shift
    for (genvar g = 0; g < MAX_WAITERS; g++) begin : g_cell
        localparam int NXT = (g + 1) % MAX_WAITERS;
        efrg_cell #(
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl[g]),
            .i_new_id   (i_requester_id),
            .i_new_time (i_last_service_time),
            .i_nbr_id   (w_id[NXT]),
            .i_nbr_time (w_time[NXT]),
            .o_id       (w_id[g]),
            .o_time     (w_time[g])
        );
    end

    // deadline tracker watching the head cell as the row rotates
    efrg_pick #(
        .TIME_BITS   (TIME_BITS),
        .MAX_WAITERS (MAX_WAITERS)
    ) u_pick (
        .i_clk      (i_clk),
        .i_step     (w_scan_step),
        .i_first    (r_scan_idx == '0),
        .i_idx      (r_scan_idx),
        .i_id       (w_id[0]),
        .i_time     (w_time[0]),
        .i_burnout  (r_burnout),
        .o_best_idx (w_best_idx),
        .o_best_id  (w_best_id)
    );

    // result word
    assign o_done          = r_done;
    assign o_grant_valid   = r_grant;
    assign o_granted_id    = r_gid_out;
    assign o_resource_free = r_free;
    assign o_ready_time    = r_ready;
    assign o_overflow      = r_ovf;

endmodule
